FILE: hdl/swnd_pkg.sv
// swnd_pkg: shared constants, types and helpers for the sliding window sender.
// Used by every module under hdl/; depends on nothing.
`default_nettype none
package swnd_pkg;

  localparam int WINDOW      = 8;
  localparam int SEQ_BITS    = 16;
  localparam int QUEUE_DEPTH = 1024;
  localparam int MAX_OUT     = 8;
  localparam int EXPIRE_W    = 20;
  localparam int CMD_W       = 2;
  localparam int ACTION_W    = 2;
  localparam int OUT_SEQ_W   = 16;
  localparam int INFL_W      = $clog2(WINDOW + 1);
  localparam int CNT_W       = $clog2(MAX_OUT + 1);

  localparam logic [EXPIRE_W-1:0] EXPIRE_RESET = EXPIRE_W'(1000);

  localparam logic [CMD_W-1:0] CMD_ENQ  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_ACK  = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_TICK = CMD_W'(2);

  localparam logic [ACTION_W-1:0] ACT_SEND   = ACTION_W'(0);
  localparam logic [ACTION_W-1:0] ACT_RETX   = ACTION_W'(1);
  localparam logic [ACTION_W-1:0] ACT_REJECT = ACTION_W'(2);

  typedef logic [SEQ_BITS-1:0] seq_t;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_ACK,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    seq_t     ack_seq;
  } swnd_op_t;

  // number of consecutive set bits from bit 0
  function automatic logic [INFL_W-1:0] lead_ones(input logic [WINDOW-1:0] bits);
    logic [INFL_W-1:0] n;
    logic              run;
    n   = '0;
    run = 1'b1;
    for (int i = 0; i < WINDOW; i++) begin
      run = run & bits[i];
      if (run) begin
        n = n + INFL_W'(1);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/swnd_front.sv
// swnd_front: accepts command transactions and classifies them into queue ops.
// Acks that fail the checksum and unknown commands are dropped here. Uses swnd_pkg.
`default_nettype none
module swnd_front (
  input  wire logic                      start,
  input  wire logic                      q_full,
  input  wire logic [swnd_pkg::CMD_W-1:0] in_cmd,
  input  wire logic [15:0]               in_ack_seq,
  input  wire logic                      in_ack_ok,
  output logic                           busy,
  output logic                           q_push,
  output swnd_pkg::swnd_op_t             q_wdata
);
  import swnd_pkg::*;

  logic accept;
  logic keep;

  assign busy   = q_full;
  assign accept = start & ~q_full;

  always_comb begin
    keep            = 1'b0;
    q_wdata.kind    = OP_TICK;
    q_wdata.ack_seq = SEQ_BITS'(in_ack_seq);
    unique case (in_cmd)
      CMD_ENQ: begin
        keep         = 1'b1;
        q_wdata.kind = OP_ENQ;
      end
      CMD_ACK: begin
        keep         = in_ack_ok;
        q_wdata.kind = OP_ACK;
      end
      CMD_TICK: begin
        keep         = 1'b1;
        q_wdata.kind = OP_TICK;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = accept & keep;

endmodule
`default_nettype wire

FILE: hdl/swnd_fifo.sv
// swnd_fifo: two-entry queue of classified ops between front and back.
// Uses swnd_pkg for the op type.
`default_nettype none
module swnd_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire swnd_pkg::swnd_op_t wdata,
  input  wire logic               pop,
  output swnd_pkg::swnd_op_t     rdata,
  output logic                    empty,
  output logic                    full
);
  import swnd_pkg::*;

  swnd_op_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign empty   = (count_r == 2'd0);
  assign full    = (count_r == 2'd2);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/swnd_back.sv
// swnd_back: executes queued ops on the window state and drives results.
// Holds sequence numbers, ack bitmap, countdown timer and expiry register. Uses swnd_pkg.
`default_nettype none
module swnd_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire swnd_pkg::swnd_op_t              q_rdata,
  input  wire logic                            q_empty,
  output logic                                 q_pop,
  input  wire logic                            cfg_valid,
  input  wire logic [swnd_pkg::EXPIRE_W-1:0]   cfg_data,
  output logic                                 idle,
  output logic                                 out_strobe,
  output logic [swnd_pkg::ACTION_W-1:0]        out_action,
  output logic [swnd_pkg::OUT_SEQ_W-1:0]       out_seq,
  output logic                                 out_last
);
  import swnd_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  localparam seq_t QDEPTH = SEQ_BITS'(QUEUE_DEPTH);

  state_t                state_r, state_nxt;
  seq_t                  base_r, base_nxt;
  seq_t                  next_free_r, next_free_nxt;
  logic [INFL_W-1:0]     infl_r, infl_nxt;
  logic [WINDOW-1:0]     acked_r, acked_nxt;
  logic                  run_r, run_nxt;
  logic [EXPIRE_W-1:0]   left_r, left_nxt;
  logic [EXPIRE_W-1:0]   expire_r, expire_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ack_pend_r, ack_pend_nxt;
  logic                  ostb_r, ostb_nxt;
  logic [ACTION_W-1:0]   oact_r, oact_nxt;
  logic [OUT_SEQ_W-1:0]  oseq_r, oseq_nxt;
  logic                  olast_r, olast_nxt;

  seq_t              queued;
  seq_t              off;
  logic [WINDOW-1:0] set_bits;
  logic [INFL_W-1:0] slide;
  logic              can_send;
  logic              more;
  logic              r;

  assign queued   = next_free_r - base_r - SEQ_BITS'(infl_r);
  assign off      = q_rdata.ack_seq - base_r;
  assign can_send = (queued != '0) && (infl_r < INFL_W'(WINDOW)) &&
                    (cnt_r < CNT_W'(MAX_OUT));
  assign more     = (queued != SEQ_BITS'(1)) &&
                    (infl_r + INFL_W'(1) < INFL_W'(WINDOW)) &&
                    (cnt_r + CNT_W'(1) < CNT_W'(MAX_OUT));

  assign idle       = (state_r == ST_IDLE);
  assign q_pop      = (state_r == ST_IDLE) & ~q_empty;
  assign out_strobe = ostb_r;
  assign out_action = oact_r;
  assign out_seq    = oseq_r;
  assign out_last   = olast_r;

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    next_free_nxt = next_free_r;
    infl_nxt      = infl_r;
    acked_nxt     = acked_r;
    run_nxt       = run_r;
    left_nxt      = left_r;
    expire_nxt    = expire_r;
    cnt_nxt       = cnt_r;
    ack_pend_nxt  = ack_pend_r;
    ostb_nxt      = 1'b0;
    oact_nxt      = oact_r;
    oseq_nxt      = oseq_r;
    olast_nxt     = olast_r;
    set_bits      = acked_r;
    slide         = '0;
    r             = run_r;

    if (cfg_valid && state_r == ST_IDLE && q_empty) begin
      expire_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_rdata.kind)
            OP_ENQ: begin
              if (queued >= QDEPTH) begin
                ostb_nxt  = 1'b1;
                oact_nxt  = ACT_REJECT;
                oseq_nxt  = OUT_SEQ_W'(next_free_r);
                olast_nxt = 1'b1;
              end else begin
                next_free_nxt = next_free_r + SEQ_BITS'(1);
                cnt_nxt       = '0;
                ack_pend_nxt  = 1'b0;
                state_nxt     = ST_SEND;
              end
            end
            OP_ACK: begin
              if (off < SEQ_BITS'(infl_r)) begin
                set_bits = acked_r | (WINDOW'(1) << off[$clog2(WINDOW+1)-1:0]);
                if (off == '0) begin
                  slide        = lead_ones(set_bits);
                  acked_nxt    = set_bits >> slide;
                  base_nxt     = base_r + SEQ_BITS'(slide);
                  infl_nxt     = infl_r - slide;
                  cnt_nxt      = '0;
                  ack_pend_nxt = 1'b1;
                  state_nxt    = ST_SEND;
                end else begin
                  acked_nxt = set_bits;
                end
              end
              if (off != '0 || off >= SEQ_BITS'(infl_r)) begin
                if ((queued != '0 || infl_r != '0) && !run_r) begin
                  run_nxt  = 1'b1;
                  left_nxt = expire_r;
                end
              end
            end
            OP_TICK: begin
              if (run_r) begin
                if (left_r <= EXPIRE_W'(1)) begin
                  if (infl_r == '0) begin
                    run_nxt = 1'b0;
                  end else begin
                    ostb_nxt  = 1'b1;
                    oact_nxt  = ACT_RETX;
                    oseq_nxt  = OUT_SEQ_W'(base_r);
                    olast_nxt = 1'b1;
                    left_nxt  = expire_r;
                  end
                end else begin
                  left_nxt = left_r - EXPIRE_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEND: begin
        if (can_send) begin
          ostb_nxt  = 1'b1;
          oact_nxt  = ACT_SEND;
          oseq_nxt  = OUT_SEQ_W'(base_r + SEQ_BITS'(infl_r));
          olast_nxt = ~more;
          infl_nxt  = infl_r + INFL_W'(1);
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          if (infl_r == INFL_W'(WINDOW) && !r) begin
            r        = 1'b1;
            left_nxt = expire_r;
          end
          if (infl_r == '0 && queued == '0) begin
            r = 1'b0;
          end
          if (ack_pend_r && !(queued == '0 && infl_r == '0) && !r) begin
            r        = 1'b1;
            left_nxt = expire_r;
          end
          run_nxt   = r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      next_free_r <= '0;
      infl_r      <= '0;
      acked_r     <= '0;
      run_r       <= 1'b0;
      left_r      <= '0;
      expire_r    <= EXPIRE_RESET;
      cnt_r       <= '0;
      ack_pend_r  <= 1'b0;
      ostb_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_free_r <= next_free_nxt;
      infl_r      <= infl_nxt;
      acked_r     <= acked_nxt;
      run_r       <= run_nxt;
      left_r      <= left_nxt;
      expire_r    <= expire_nxt;
      cnt_r       <= cnt_nxt;
      ack_pend_r  <= ack_pend_nxt;
      ostb_r      <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oact_r  <= oact_nxt;
    oseq_r  <= oseq_nxt;
    olast_r <= olast_nxt;
  end

  a_infl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    infl_r <= INFL_W'(WINDOW))
    else $error("in-flight count exceeds window");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queued <= QDEPTH)
    else $error("queued count exceeds queue depth");

  a_acked_range: assert property (@(posedge clk) disable iff (!rst_n)
    (acked_r >> infl_r) == '0)
    else $error("ack bit set beyond in-flight range");

  a_send_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND && can_send) |=> (out_strobe && out_action == ACT_SEND))
    else $error("send slot did not produce a transmit result");

endmodule
`default_nettype wire

FILE: hdl/sliding_window_sender.sv
// sliding_window_sender: top level of the selective-repeat sender bookkeeping.
// Instantiates swnd_front, swnd_fifo and swnd_back; uses swnd_pkg.
//
// Usage:
//   Command channel: drive in_cmd/in_ack_seq/in_ack_ok with start; the
//   transaction is taken on a clock edge where start is high and busy is low.
//   Commands are enqueue, acknowledgement and timer tick. Acks failing the
//   checksum and unknown commands are dropped at the front.
//   Result channel: each result is shown for one cycle with out_strobe high;
//   out_last marks the final result of a command. The receiver cannot stall.
//   Config channel: cfg_data carries expire_ticks, written when cfg_valid
//   and cfg_ready are high; cfg_ready is high only while the block is idle.
// Timing:
//   A two-entry op queue decouples the front from the back, so busy rises
//   only when two ops wait. The back takes one op per cycle except for an
//   accepted enqueue or a base ack, which step through decode, one send
//   step per packet (at most 8) and a closing step before the next op.
//   Rejects and retransmits leave from the decode step, sends from the send steps.
// Reset: synchronous, active low; window empty, timer stopped,
//   expire_ticks back to 1000, queue emptied.
`default_nettype none
module sliding_window_sender (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [swnd_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [15:0]                      in_ack_seq,
  input  wire logic                             in_ack_ok,
  output logic                                  out_strobe,
  output logic [swnd_pkg::ACTION_W-1:0]         out_action,
  output logic [swnd_pkg::OUT_SEQ_W-1:0]        out_seq,
  output logic                                  out_last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [swnd_pkg::EXPIRE_W-1:0]    cfg_data
);
  import swnd_pkg::*;

  logic     q_push, q_pop, q_empty, q_full, back_idle;
  swnd_op_t q_wdata, q_rdata;

  assign cfg_ready = back_idle & q_empty;

  swnd_front u_front (
    .start      (start),
    .q_full     (q_full),
    .in_cmd     (in_cmd),
    .in_ack_seq (in_ack_seq),
    .in_ack_ok  (in_ack_ok),
    .busy       (busy),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  swnd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  swnd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rdata    (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .idle       (back_idle),
    .out_strobe (out_strobe),
    .out_action (out_action),
    .out_seq    (out_seq),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire
